FILE: rtl/ors_pkg.sv
`timescale 1ns / 1ps

package ors_pkg;

    localparam int unsigned ROM_BITS    = 64;
    localparam int unsigned POS_W       = 7;
    localparam int unsigned MAX_DEVICES = 8;

    localparam logic [POS_W-1:0] NO_FORK       = 7'd64;
    localparam logic [POS_W-1:0] COUNT_MAX     = 7'd127;
    localparam logic [POS_W-1:0] DEVICE_LIMIT  = POS_W'(MAX_DEVICES);
    localparam logic [5:0]       LAST_POSITION = 6'd63;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_BEGIN = 2'd1;
    localparam logic [1:0] MODE_PAIR  = 2'd2;

    localparam logic [2:0] ST_TAKEN   = 3'd0;
    localparam logic [2:0] ST_MORE    = 3'd1;
    localparam logic [2:0] ST_LAST    = 3'd2;
    localparam logic [2:0] ST_NOBODY  = 3'd3;
    localparam logic [2:0] ST_NOREPLY = 3'd4;
    localparam logic [2:0] ST_BEGUN   = 3'd5;
    localparam logic [2:0] ST_IGNORED = 3'd6;
    localparam logic [2:0] ST_CLEARED = 3'd7;

    typedef struct packed {
        logic [1:0] mode;
        logic       presence;
        logic       id_bit;
        logic       complement_bit;
    } ors_item_t;

    typedef struct packed {
        logic                write_bit;
        logic [2:0]          status;
        logic [ROM_BITS-1:0] rom_id;
        logic [2:0]          device_index;
    } ors_result_t;

    typedef struct packed {
        logic                in_pass;
        logic [POS_W-1:0]    bit_position;
        logic [POS_W-1:0]    previous_fork;
        logic [POS_W-1:0]    pass_fork;
        logic [ROM_BITS-1:0] previous_rom;
        logic [ROM_BITS-1:0] building_rom;
        logic [POS_W-1:0]    devices_found;
    } ors_state_t;

    localparam ors_state_t STATE_RESET = '{
        in_pass:       1'b0,
        bit_position:  '0,
        previous_fork: NO_FORK,
        pass_fork:     NO_FORK,
        previous_rom:  '0,
        building_rom:  '0,
        devices_found: '0
    };

endpackage

FILE: rtl/ors_item_if.sv
`timescale 1ns / 1ps

interface ors_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;

    modport source (output valid, output mode, output presence, output id_bit,
                    output complement_bit, input ready);
    modport sink (input valid, input mode, input presence, input id_bit,
                  input complement_bit, output ready);
endinterface

FILE: rtl/ors_result_if.sv
`timescale 1ns / 1ps

interface ors_result_if;
    logic        valid;
    logic        ready;
    logic        write_bit;
    logic [2:0]  status;
    logic [63:0] rom_id;
    logic [2:0]  device_index;

    modport source (output valid, output write_bit, output status, output rom_id,
                    output device_index, input ready);
    modport sink (input valid, input write_bit, input status, input rom_id,
                  input device_index, output ready);
endinterface

FILE: rtl/ors_step.sv
`timescale 1ns / 1ps

module ors_step (
    input  ors_pkg::ors_item_t   item,
    input  ors_pkg::ors_state_t  cur,
    output ors_pkg::ors_state_t  nxt,
    output ors_pkg::ors_result_t res
);

    logic [5:0]                   p;
    logic [ors_pkg::POS_W-1:0]    p_ext;
    logic                         dir;
    logic [ors_pkg::ROM_BITS-1:0] rom_built;
    logic [ors_pkg::POS_W-1:0]    count_next;
    logic [ors_pkg::POS_W-1:0]    fork_next;

    assign p     = cur.bit_position[5:0];
    assign p_ext = {1'b0, p};

    always_comb
    begin
        nxt        = cur;
        res        = '0;
        dir        = 1'b0;
        fork_next  = cur.pass_fork;
        rom_built  = cur.building_rom;
        count_next = (cur.devices_found < ors_pkg::COUNT_MAX)
                     ? cur.devices_found + 7'd1 : ors_pkg::COUNT_MAX;
        case (item.mode)
            ors_pkg::MODE_CLEAR:
            begin
                nxt        = ors_pkg::STATE_RESET;
                res.status = ors_pkg::ST_CLEARED;
            end
            ors_pkg::MODE_BEGIN:
            begin
                if (item.presence)
                begin
                    nxt.in_pass      = 1'b1;
                    nxt.bit_position = '0;
                    nxt.pass_fork    = ors_pkg::NO_FORK;
                    nxt.building_rom = '0;
                    res.status       = ors_pkg::ST_BEGUN;
                end
                else
                begin
                    nxt.in_pass = 1'b0;
                    res.status  = ors_pkg::ST_NOBODY;
                end
            end
            ors_pkg::MODE_PAIR:
            begin
                if (!cur.in_pass)
                begin
                    res.status = ors_pkg::ST_IGNORED;
                end
                else if (item.id_bit && item.complement_bit)
                begin
                    nxt.in_pass = 1'b0;
                    res.status  = ors_pkg::ST_NOREPLY;
                end
                else
                begin
                    if (item.id_bit != item.complement_bit)
                    begin
                        dir = item.id_bit;
                    end
                    else if (p_ext == cur.previous_fork)
                    begin
                        dir = 1'b1;
                    end
                    else
                    begin
                        dir = (p_ext > cur.previous_fork) ? 1'b0 : cur.previous_rom[p];
                        if (!dir)
                        begin
                            fork_next = p_ext;
                        end
                    end
                    rom_built        = cur.building_rom | ({63'b0, dir} << p);
                    nxt.pass_fork    = fork_next;
                    nxt.building_rom = rom_built;
                    nxt.bit_position = p_ext + 7'd1;
                    res.write_bit    = dir;
                    if (p != ors_pkg::LAST_POSITION)
                    begin
                        res.status = ors_pkg::ST_TAKEN;
                    end
                    else
                    begin
                        nxt.previous_fork = fork_next;
                        nxt.previous_rom  = rom_built;
                        nxt.devices_found = count_next;
                        nxt.in_pass       = 1'b0;
                        nxt.bit_position  = '0;
                        res.rom_id        = rom_built;
                        res.device_index  = cur.devices_found[2:0];
                        res.status = ((fork_next != ors_pkg::NO_FORK)
                                      && (count_next < ors_pkg::DEVICE_LIMIT))
                                     ? ors_pkg::ST_MORE : ors_pkg::ST_LAST;
                    end
                end
            end
            default:
            begin
                res.status = ors_pkg::ST_IGNORED;
            end
        endcase
    end

endmodule

FILE: rtl/onewire_rom_search_engine.sv
// Throughput: one item per cycle unless the result stalls. The input and result
// registers each hold one beat; an item's result beat is offered once it moves
// from the input register into the result register, updating the search state.
// A stalled result only stops input once the input register is also full.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// search state to its cleared values.
`timescale 1ns / 1ps

module onewire_rom_search_engine (
    input logic         clk,
    input logic         rst_n,
    ors_item_if.sink    item,
    ors_result_if.source result
);

    logic                 s1_valid_reg;
    ors_pkg::ors_item_t   s1_item_reg;
    logic                 out_valid_reg;
    ors_pkg::ors_result_t out_result_reg;
    ors_pkg::ors_state_t  state_reg;
    ors_pkg::ors_state_t  state_next;
    ors_pkg::ors_result_t result_next;
    logic                 advance;
    logic                 in_take;

    assign advance = s1_valid_reg && (!out_valid_reg || result.ready);
    assign in_take = item.valid && item.ready;

    assign item.ready = !s1_valid_reg || advance;

    ors_step u_step (
        .item (s1_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ors_pkg::STATE_RESET;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.mode           <= item.mode;
            s1_item_reg.presence       <= item.presence;
            s1_item_reg.id_bit         <= item.id_bit;
            s1_item_reg.complement_bit <= item.complement_bit;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.write_bit    = out_result_reg.write_bit;
    assign result.status       = out_result_reg.status;
    assign result.rom_id       = out_result_reg.rom_id;
    assign result.device_index = out_result_reg.device_index;

endmodule

FILE: rtl/ors_checker.sv
`timescale 1ns / 1ps

module ors_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        write_bit,
    input logic [2:0]  status,
    input logic [63:0] rom_id,
    input logic [2:0]  device_index
);

    logic found;

    assign found = (status == ors_pkg::ST_MORE) || (status == ors_pkg::ST_LAST);

    // A result beat that is not taken stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(rom_id))
        else $error("result beat dropped or changed while stalled");

    a_rom_only_on_find: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> rom_id == 64'd0)
        else $error("rom_id nonzero on a beat that reports no device");

    a_index_only_on_find: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> device_index == 3'd0)
        else $error("device_index nonzero on a beat that reports no device");

    a_write_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found && (status != ors_pkg::ST_TAKEN) |-> !write_bit)
        else $error("write_bit set on a beat that takes no bit");

endmodule

bind onewire_rom_search_engine ors_checker u_ors_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .write_bit    (result.write_bit),
    .status       (result.status),
    .rom_id       (result.rom_id),
    .device_index (result.device_index)
);
